>>> hw/rtl/noa_pkg.sv
// Shared types for the netlist operator ALU: operator codes, pipeline
// enable bundle and the fixed port word. No dependencies.
package noa_pkg;

  localparam int PortW = 64;

  typedef logic [PortW-1:0] port_t;

  typedef enum logic [4:0] {
    KIND_COPY  = 5'd0,
    KIND_NOT   = 5'd1,
    KIND_AND   = 5'd2,
    KIND_OR    = 5'd3,
    KIND_XOR   = 5'd4,
    KIND_ADD   = 5'd5,
    KIND_SUB   = 5'd6,
    KIND_MUL   = 5'd7,
    KIND_SHL   = 5'd8,
    KIND_SHRU  = 5'd9,
    KIND_SHRS  = 5'd10,
    KIND_EQ    = 5'd11,
    KIND_ULT   = 5'd12,
    KIND_SLT   = 5'd13,
    KIND_ZEXT  = 5'd14,
    KIND_SEXT  = 5'd15,
    KIND_BAL   = 5'd16,
    KIND_CNT   = 5'd17,
    KIND_BYTE  = 5'd18,
    KIND_SLICE = 5'd19,
    KIND_VEC   = 5'd20
  } kind_t;

  typedef struct packed {
    logic s1;
    logic s2;
  } stage_en_t;

endpackage

>>> hw/rtl/netlist_operator_alu.sv
// Netlist operator ALU top level: three-stage pipeline with output register.
// Depends on noa_pkg and noa_mul.
//
// Usage:
//   Input channel in_* carries one operator beat: kind, three operands and
//   the width, offset and element fields. Output channel out_* returns one
//   beat per input beat, in order: result masked to result_width, and fault.
//   Both channels use valid/ready; a beat moves when both are high.
//   A beat accepted on in_* moves through the stage 1 and stage 2 registers
//   and is presented on out_* from the stage 3 register. Throughput: one beat
//   per cycle unless out_ready stalls; the multiplier is split into partial
//   products in stage 1 and summed in stage 2. Stage 1 clamps widths and
//   forms flags and vector positions, stage 2 evaluates the operator, stage 3
//   masks and holds the result. When out_ready is low, each stage holds as
//   long as the one after it is full; empty stages still fill, so in_ready
//   stays high until all three stages hold beats.
//   cfg_we writes strict_mode from cfg_wdata; write it only
//   while the pipeline is empty.
//   Reset (rst_n low, synchronous) drops all beats in flight and clears
//   strict_mode.
module netlist_operator_alu #(
  parameter int DATA_WIDTH = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic                 cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [4:0]           in_kind,
  input  noa_pkg::port_t       in_operand_a,
  input  noa_pkg::port_t       in_operand_b,
  input  noa_pkg::port_t       in_operand_c,
  input  logic [6:0]           in_result_width,
  input  logic [6:0]           in_source_width,
  input  logic [5:0]           in_bit_offset,
  input  logic [6:0]           in_element_count,
  input  logic [6:0]           in_element_width,
  input  logic                 in_inject_mode,
  output logic                 out_valid,
  input  logic                 out_ready,
  output noa_pkg::port_t       out_result,
  output logic                 out_fault
);

  localparam int DW = DATA_WIDTH;
  localparam int CW = $clog2(DW + 1);
  localparam int SB = $clog2(DW);
  localparam int PW = 7 + CW;
  localparam int NB = DW / 8;

  function automatic logic [CW-1:0] clamp_w(input logic [6:0] v);
    logic [CW-1:0] r;
    if (v == 7'd0) begin
      r = CW'(1);
    end else if (v > 7'(DW)) begin
      r = CW'(DW);
    end else begin
      r = v[CW-1:0];
    end
    return r;
  endfunction

  // handshake and valid chain
  logic v1_r, v2_r, v3_r;
  logic en1, en2, en3;
  noa_pkg::stage_en_t mul_en;
  logic strict_r;

  assign en3 = !v3_r || out_ready;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_ready = en1;
  assign mul_en.s1 = en1;
  assign mul_en.s2 = en2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
      v3_r     <= 1'b0;
      strict_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (cfg_we) strict_r <= cfg_wdata;
    end
  end

  // stage 1: clamp widths, masks, flags, vector position
  logic [DW-1:0] a0, b0, c0;
  logic [CW-1:0] w0, sw0, ew0, wm1_0, sm1_0;
  logic [DW-1:0] wmask0, smask0, emask0;
  logic [PW-1:0] pos0;

  assign a0  = in_operand_a[DW-1:0];
  assign b0  = in_operand_b[DW-1:0];
  assign c0  = in_operand_c[DW-1:0];
  assign w0  = clamp_w(in_result_width);
  assign sw0 = clamp_w(in_source_width);
  assign ew0 = clamp_w(in_element_width);
  assign wmask0 = ~({DW{1'b1}} << w0);
  assign smask0 = ~({DW{1'b1}} << sw0);
  assign emask0 = ~({DW{1'b1}} << ew0);
  assign wm1_0  = w0 - CW'(1);
  assign sm1_0  = sw0 - CW'(1);
  assign pos0   = PW'(b0[6:0]) * PW'(ew0);

  noa_pkg::kind_t kind1_r;
  logic [DW-1:0]  a1_r, b1_r, c1_r, wmask1_r, smask1_r, emask1_r;
  logic [CW-1:0]  w1_r;
  logic [SB-1:0]  wtop1_r, stop1_r, sh_amt1_r, pos_amt1_r;
  logic [5:0]     off1_r;
  logic           sh_over1_r, in_range1_r, pos_over1_r, inject1_r;
  logic           b_ne_c1_r, c_nz1_r, b_z1_r, ac_eq1_r;

  always_ff @(posedge clk) begin
    if (en1) begin
      kind1_r     <= noa_pkg::kind_t'(in_kind);
      a1_r        <= a0;
      b1_r        <= b0;
      c1_r        <= c0;
      wmask1_r    <= wmask0;
      smask1_r    <= smask0;
      emask1_r    <= emask0;
      w1_r        <= w0;
      wtop1_r     <= wm1_0[SB-1:0];
      stop1_r     <= sm1_0[SB-1:0];
      sh_amt1_r   <= b0[SB-1:0];
      sh_over1_r  <= b0 >= DW'(w0);
      in_range1_r <= b0 < DW'(in_element_count);
      pos_over1_r <= pos0 >= PW'(DW);
      pos_amt1_r  <= pos0[SB-1:0];
      off1_r      <= in_bit_offset;
      inject1_r   <= in_inject_mode;
      b_ne_c1_r   <= b0 != c0;
      c_nz1_r     <= c0 != '0;
      b_z1_r      <= b0 == '0;
      ac_eq1_r    <= ((a0 ^ c0) & wmask0) == '0;
    end
  end

  // stage 2: operator evaluation
  logic [DW-1:0] prod;

  noa_mul #(.DW(DW)) u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (a0),
    .b    (b0),
    .prod (prod)
  );

  logic [DW-1:0] res2_nxt, aw, sx, av_s, bv_s, bm, em, a_inc, a_dec;
  logic          neg, less, sa, sb;
  logic [CW-1:0] nbytes;

  always_comb begin
    aw     = a1_r & wmask1_r;
    neg    = aw[wtop1_r];
    sx     = aw | (neg ? ~wmask1_r : '0);
    av_s   = a1_r & smask1_r;
    bv_s   = b1_r & smask1_r;
    sa     = av_s[stop1_r];
    sb     = bv_s[stop1_r];
    less   = (sa != sb) ? sa : (av_s < bv_s);
    a_inc  = a1_r + DW'(1);
    a_dec  = a1_r - DW'(1);
    em     = emask1_r << pos_amt1_r;
    nbytes = w1_r >> 3;
    bm     = '0;
    for (int k = 0; k < NB; k++) begin
      if (CW'(k) < nbytes) begin
        bm[k*8 +: 8] = c1_r[k] ? b1_r[k*8 +: 8] : a1_r[k*8 +: 8];
      end
    end
    case (kind1_r)
      noa_pkg::KIND_COPY:  res2_nxt = a1_r;
      noa_pkg::KIND_NOT:   res2_nxt = ~a1_r;
      noa_pkg::KIND_AND:   res2_nxt = a1_r & b1_r;
      noa_pkg::KIND_OR:    res2_nxt = a1_r | b1_r;
      noa_pkg::KIND_XOR:   res2_nxt = a1_r ^ b1_r;
      noa_pkg::KIND_ADD:   res2_nxt = a1_r + b1_r;
      noa_pkg::KIND_SUB:   res2_nxt = a1_r - b1_r;
      noa_pkg::KIND_SHL:   res2_nxt = sh_over1_r ? '0 : (aw << sh_amt1_r);
      noa_pkg::KIND_SHRU:  res2_nxt = sh_over1_r ? '0 : (aw >> sh_amt1_r);
      noa_pkg::KIND_SHRS: begin
        if (sh_over1_r) begin
          res2_nxt = neg ? '1 : '0;
        end else begin
          res2_nxt = DW'($signed(sx) >>> sh_amt1_r);
        end
      end
      noa_pkg::KIND_EQ:    res2_nxt = DW'(av_s == bv_s);
      noa_pkg::KIND_ULT:   res2_nxt = DW'(av_s < bv_s);
      noa_pkg::KIND_SLT:   res2_nxt = DW'(less);
      noa_pkg::KIND_ZEXT:  res2_nxt = av_s;
      noa_pkg::KIND_SEXT:  res2_nxt = av_s | (sa ? ~smask1_r : '0);
      noa_pkg::KIND_BAL: begin
        if (b_ne_c1_r) begin
          res2_nxt = c_nz1_r ? a_dec : a_inc;
        end else begin
          res2_nxt = a1_r;
        end
      end
      noa_pkg::KIND_CNT: begin
        if (b_z1_r) begin
          res2_nxt = a1_r;
        end else begin
          res2_nxt = ac_eq1_r ? '0 : a_inc;
        end
      end
      noa_pkg::KIND_BYTE:  res2_nxt = bm;
      noa_pkg::KIND_SLICE: res2_nxt = a1_r >> off1_r;
      noa_pkg::KIND_VEC: begin
        if (!in_range1_r) begin
          res2_nxt = '0;
        end else if (inject1_r) begin
          res2_nxt = pos_over1_r ? a1_r : ((a1_r & ~em) | ((c1_r << pos_amt1_r) & em));
        end else begin
          res2_nxt = pos_over1_r ? '0 : (a1_r >> pos_amt1_r);
        end
      end
      default:             res2_nxt = '0;
    endcase
  end

  logic [DW-1:0] res2_r, wmask2_r;
  logic          mul2_r, fault2_r;

  always_ff @(posedge clk) begin
    if (en2) begin
      res2_r   <= res2_nxt;
      wmask2_r <= wmask1_r;
      mul2_r   <= kind1_r == noa_pkg::KIND_MUL;
      fault2_r <= (kind1_r == noa_pkg::KIND_VEC) && !in_range1_r && strict_r;
    end
  end

  // stage 3: select product, mask, hold for the receiver
  logic [DW-1:0] res3_nxt, res3_r;
  logic          fault3_r;

  assign res3_nxt = (mul2_r ? prod : res2_r) & wmask2_r;

  always_ff @(posedge clk) begin
    if (en3) begin
      res3_r   <= res3_nxt;
      fault3_r <= fault2_r;
    end
  end

  assign out_valid  = v3_r;
  assign out_result = noa_pkg::port_t'(res3_r);
  assign out_fault  = fault3_r;

endmodule

>>> hw/rtl/noa_mul.sv
// Two-stage low-half multiplier for the netlist operator ALU.
// Splits operands into halves; uses noa_pkg::stage_en_t for stall control.
module noa_mul #(
  parameter int DW = 64
) (
  input  logic              clk,
  input  noa_pkg::stage_en_t en,
  input  logic [DW-1:0]     a,
  input  logic [DW-1:0]     b,
  output logic [DW-1:0]     prod
);

  localparam int LO = (DW + 1) / 2;
  localparam int HI = DW - LO;

  logic [LO-1:0]   a_lo, b_lo;
  logic [HI-1:0]   a_hi, b_hi;
  logic [2*LO-1:0] pp_ll_r;
  logic [HI-1:0]   pp_lh_r, pp_hl_r;
  logic [DW-1:0]   prod_r, prod_nxt;

  assign a_lo = a[LO-1:0];
  assign b_lo = b[LO-1:0];
  assign a_hi = a[DW-1:LO];
  assign b_hi = b[DW-1:LO];

  always_ff @(posedge clk) begin
    if (en.s1) begin
      pp_ll_r <= a_lo * b_lo;
      pp_lh_r <= a_lo[HI-1:0] * b_hi;
      pp_hl_r <= a_hi * b_lo[HI-1:0];
    end
  end

  assign prod_nxt = pp_ll_r[DW-1:0] + {pp_lh_r + pp_hl_r, {LO{1'b0}}};

  always_ff @(posedge clk) begin
    if (en.s2) begin
      prod_r <= prod_nxt;
    end
  end

  assign prod = prod_r;

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// Testbench for netlist_operator_alu: random and directed operator beats with
// idling on both channels, checked against an in-bench operator evaluator.
// Depends on noa_pkg and the netlist_operator_alu RTL.
module tb;

  localparam int unsigned LIMIT = 200000;
  localparam int unsigned RAND_PER_PHASE = 175;
  localparam logic [4:0] KIND_UNUSED_TOP = 5'd31;
  localparam logic [63:0] ONES = {64{1'b1}};

  typedef struct {
    logic [4:0]      kind;
    noa_pkg::port_t  a;
    noa_pkg::port_t  b;
    noa_pkg::port_t  c;
    logic [6:0]      result_width;
    logic [6:0]      source_width;
    logic [5:0]      bit_offset;
    logic [6:0]      element_count;
    logic [6:0]      element_width;
    logic            inject_mode;
  } op_beat_t;

  typedef struct {
    logic [63:0] result;
    logic        fault;
  } op_result_t;

  class op_result_ledger_t;
    op_result_t  pending_results[$];
    int unsigned errors;

    function logic [63:0] low_bits(longint unsigned n);
      if (n >= 64) return ONES;
      if (n == 0) return '0;
      return (64'd1 << n) - 64'd1;
    endfunction

    function int unsigned clamp_w(logic [6:0] v);
      if (v == 7'd0) return 1;
      if (v > 7'd64) return 64;
      return 32'(v);
    endfunction

    function op_result_t eval_operator(op_beat_t op, bit strict);
      op_result_t  res;
      logic [63:0] a, b, c, r, wm, sm, em, av, bv, src, pos;
      int unsigned w, sw, ew, nb;
      bit          neg, less;
      a = op.a;
      b = op.b;
      c = op.c;
      w = clamp_w(op.result_width);
      sw = clamp_w(op.source_width);
      ew = clamp_w(op.element_width);
      wm = low_bits(w);
      sm = low_bits(sw);
      r = '0;
      res.fault = 1'b0;
      case (op.kind)
        noa_pkg::KIND_COPY: r = a;
        noa_pkg::KIND_NOT:  r = ~a;
        noa_pkg::KIND_AND:  r = a & b;
        noa_pkg::KIND_OR:   r = a | b;
        noa_pkg::KIND_XOR:  r = a ^ b;
        noa_pkg::KIND_ADD:  r = a + b;
        noa_pkg::KIND_SUB:  r = a - b;
        noa_pkg::KIND_MUL:  r = a * b;
        noa_pkg::KIND_SHL, noa_pkg::KIND_SHRU, noa_pkg::KIND_SHRS: begin
          av = a & wm;
          neg = (op.kind == noa_pkg::KIND_SHRS) && av[w-1];
          if (b >= w) begin
            r = neg ? ONES : '0;
          end else if (op.kind == noa_pkg::KIND_SHL) begin
            r = av << b;
          end else begin
            r = av >> b;
            if (neg) r = r | (wm & ~low_bits(w - b));
          end
        end
        noa_pkg::KIND_EQ, noa_pkg::KIND_ULT, noa_pkg::KIND_SLT: begin
          av = a & sm;
          bv = b & sm;
          less = av < bv;
          if (op.kind == noa_pkg::KIND_SLT && av[sw-1] != bv[sw-1]) less = av[sw-1];
          r = (op.kind == noa_pkg::KIND_EQ) ? {63'd0, av == bv} : {63'd0, less};
        end
        noa_pkg::KIND_ZEXT, noa_pkg::KIND_SEXT: begin
          r = a & sm;
          if (op.kind == noa_pkg::KIND_SEXT && a[sw-1]) r = r | ~sm;
        end
        noa_pkg::KIND_BAL: begin
          if (b != c) r = (c != 0) ? a - 64'd1 : a + 64'd1;
          else r = a;
        end
        noa_pkg::KIND_CNT: begin
          if (b == 0) r = a;
          else if ((a & wm) == (c & wm)) r = '0;
          else r = a + 64'd1;
        end
        noa_pkg::KIND_BYTE: begin
          nb = w / 8;
          for (int k = 0; k < nb; k++) begin
            src = c[k] ? b : a;
            r[k*8 +: 8] = src[k*8 +: 8];
          end
        end
        noa_pkg::KIND_SLICE: r = a >> op.bit_offset;
        noa_pkg::KIND_VEC: begin
          if (b >= op.element_count) begin
            r = '0;
            res.fault = strict;
          end else begin
            pos = b * ew;
            if (!op.inject_mode) begin
              r = (pos >= 64) ? '0 : a >> pos;
            end else begin
              r = a;
              if (pos < 64) begin
                em = low_bits(ew) << pos;
                r = (a & ~em) | ((c << pos) & em);
              end
            end
          end
        end
        default: r = '0;
      endcase
      res.result = r & wm;
      return res;
    endfunction

    function void note_beat(op_beat_t op, bit strict);
      pending_results.push_back(eval_operator(op, strict));
    endfunction

    task flag_mismatch(string what);
      $display("ERROR at %0t: %s", $time, what);
      errors++;
    endtask

    task check_beat(logic [63:0] result, logic fault);
      op_result_t want;
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("unexpected beat result=%h fault=%b", result, fault));
        return;
      end
      want = pending_results.pop_front();
      if (result !== want.result)
        flag_mismatch($sformatf("result %h, want %h", result, want.result));
      if (fault !== want.fault)
        flag_mismatch($sformatf("fault %b, want %b", fault, want.fault));
    endtask

    task drain_check();
      if (pending_results.size() != 0)
        flag_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    endtask
  endclass

  logic            clk = 1'b0;
  logic            rst_n;
  logic            cfg_we;
  logic            cfg_wdata;
  logic            in_valid;
  logic            in_ready;
  logic [4:0]      in_kind;
  noa_pkg::port_t  in_operand_a;
  noa_pkg::port_t  in_operand_b;
  noa_pkg::port_t  in_operand_c;
  logic [6:0]      in_result_width;
  logic [6:0]      in_source_width;
  logic [5:0]      in_bit_offset;
  logic [6:0]      in_element_count;
  logic [6:0]      in_element_width;
  logic            in_inject_mode;
  logic            out_valid;
  logic            out_ready = 1'b0;
  noa_pkg::port_t  out_result;
  logic            out_fault;

  op_result_ledger_t ledger = new();
  bit                strict_now;
  bit                calm;
  int unsigned       cycles = 0;

  netlist_operator_alu #(
    .DATA_WIDTH(64)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_operand_a     (in_operand_a),
    .in_operand_b     (in_operand_b),
    .in_operand_c     (in_operand_c),
    .in_result_width  (in_result_width),
    .in_source_width  (in_source_width),
    .in_bit_offset    (in_bit_offset),
    .in_element_count (in_element_count),
    .in_element_width (in_element_width),
    .in_inject_mode   (in_inject_mode),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result       (out_result),
    .out_fault        (out_fault)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("netlist_operator_alu: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) ledger.check_beat(out_result, out_fault);
    out_ready <= calm || ($urandom_range(99) >= 13);
  end

  function automatic op_beat_t make_op(logic [4:0] kind, noa_pkg::port_t a,
                                       noa_pkg::port_t b, noa_pkg::port_t c,
                                       int unsigned rw, int unsigned sw, int unsigned off,
                                       int unsigned cnt, int unsigned ew, int unsigned inj);
    op_beat_t op;
    op.kind = kind;
    op.a = a;
    op.b = b;
    op.c = c;
    op.result_width = 7'(rw);
    op.source_width = 7'(sw);
    op.bit_offset = 6'(off);
    op.element_count = 7'(cnt);
    op.element_width = 7'(ew);
    op.inject_mode = 1'(inj);
    return op;
  endfunction

  function automatic noa_pkg::port_t rand_word();
    case ($urandom_range(7))
      0: return '0;
      1: return ONES;
      2: return 64'($urandom_range(255));
      3: return 64'd1 << $urandom_range(63);
      4: return ~(64'd1 << $urandom_range(63));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [6:0] rand_width();
    case ($urandom_range(9))
      0: return 7'd0;
      1: return 7'd64;
      2: return 7'($urandom_range(127, 65));
      3: return 7'(8 * $urandom_range(8, 1));
      default: return 7'($urandom_range(64, 1));
    endcase
  endfunction

  function automatic op_beat_t rand_op();
    op_beat_t op;
    if ($urandom_range(99) < 5) begin
      op.kind = 5'($urandom_range(KIND_UNUSED_TOP, noa_pkg::KIND_VEC + 1));
    end else begin
      op.kind = 5'($urandom_range(noa_pkg::KIND_VEC));
    end
    op.a = rand_word();
    op.b = rand_word();
    op.c = rand_word();
    op.result_width = rand_width();
    op.source_width = rand_width();
    op.bit_offset = 6'($urandom_range(63));
    if ($urandom_range(9) < 7) op.element_count = 7'($urandom_range(64, 1));
    else op.element_count = 7'($urandom_range(127));
    op.element_width = rand_width();
    op.inject_mode = 1'($urandom_range(1));
    case (op.kind)
      noa_pkg::KIND_SHL, noa_pkg::KIND_SHRU, noa_pkg::KIND_SHRS: begin
        if ($urandom_range(9) < 8) op.b = 64'($urandom_range(70));
      end
      noa_pkg::KIND_EQ, noa_pkg::KIND_ULT, noa_pkg::KIND_SLT: begin
        if ($urandom_range(3) == 0) op.b = op.a ^ ({$urandom, $urandom} << op.source_width);
      end
      noa_pkg::KIND_BAL: begin
        if ($urandom_range(2) == 0) op.b = op.c;
      end
      noa_pkg::KIND_CNT: begin
        if ($urandom_range(3) == 0) op.b = '0;
        if ($urandom_range(2) == 0) op.c = op.a ^ ({$urandom, $urandom} << op.result_width);
      end
      noa_pkg::KIND_VEC: begin
        if ($urandom_range(9) < 8) op.b = 64'($urandom_range(32'(op.element_count) + 2));
      end
      default: ;
    endcase
    return op;
  endfunction

  task automatic push_op(op_beat_t op);
    int unsigned gap;
    if (!calm && $urandom_range(99) < 13) begin
      gap = $urandom_range(3, 1);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= op.kind;
    in_operand_a <= op.a;
    in_operand_b <= op.b;
    in_operand_c <= op.c;
    in_result_width <= op.result_width;
    in_source_width <= op.source_width;
    in_bit_offset <= op.bit_offset;
    in_element_count <= op.element_count;
    in_element_width <= op.element_width;
    in_inject_mode <= op.inject_mode;
    do @(posedge clk); while (!in_ready);
    ledger.note_beat(op, strict_now);
  endtask

  task automatic write_strict(bit v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    strict_now = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (ledger.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_directed();
    op_beat_t ops[$];
    ops.push_back(make_op(noa_pkg::KIND_COPY, ONES, 0, 0, 64, 64, 0, 1, 1, 0));
    ops.push_back(make_op(noa_pkg::KIND_NOT, 0, 0, 0, 0, 64, 0, 1, 1, 0));
    ops.push_back(make_op(noa_pkg::KIND_AND, ONES, 64'hA5A5_5A5A_0F0F_F0F0, 0, 127, 64, 0,
                          1, 1, 0));
    ops.push_back(make_op(noa_pkg::KIND_OR, 0, ONES, 0, 32, 64, 0, 1, 1, 0));
    ops.push_back(make_op(noa_pkg::KIND_XOR, ONES, 64'h0123_4567_89AB_CDEF, 0, 1, 64, 0,
                          1, 1, 0));
    ops.push_back(make_op(noa_pkg::KIND_ADD, ONES, 1, 0, 64, 64, 0, 1, 1, 0));
    ops.push_back(make_op(noa_pkg::KIND_SUB, 0, 1, 0, 64, 64, 0, 1, 1, 0));
    ops.push_back(make_op(noa_pkg::KIND_MUL, ONES, ONES, 0, 64, 64, 0, 1, 1, 0));
    ops.push_back(make_op(noa_pkg::KIND_SHL, 1, 63, 0, 64, 64, 0, 1, 1, 0));
    ops.push_back(make_op(noa_pkg::KIND_SHL, ONES, 64, 0, 64, 64, 0, 1, 1, 0));
    ops.push_back(make_op(noa_pkg::KIND_SHRS, 64'h80, 3, 0, 8, 64, 0, 1, 1, 0));
    ops.push_back(make_op(noa_pkg::KIND_SHRS, 64'h80, 8, 0, 8, 64, 0, 1, 1, 0));
    ops.push_back(make_op(noa_pkg::KIND_EQ, ONES, 64'hFF, 0, 64, 8, 0, 1, 1, 0));
    ops.push_back(make_op(noa_pkg::KIND_ULT, 0, ONES, 0, 64, 64, 0, 1, 1, 0));
    ops.push_back(make_op(noa_pkg::KIND_SLT, 64'h8, 64'h7, 0, 64, 4, 0, 1, 1, 0));
    ops.push_back(make_op(noa_pkg::KIND_ZEXT, ONES, 0, 0, 64, 1, 0, 1, 1, 0));
    ops.push_back(make_op(noa_pkg::KIND_SEXT, 1, 0, 0, 64, 1, 0, 1, 1, 0));
    ops.push_back(make_op(noa_pkg::KIND_BAL, 0, 1, 0, 64, 64, 0, 1, 1, 0));
    ops.push_back(make_op(noa_pkg::KIND_CNT, 64'h1F, 1, 64'hFF, 5, 64, 0, 1, 1, 0));
    ops.push_back(make_op(noa_pkg::KIND_BYTE, ONES, 0, 64'h55, 64, 64, 0, 1, 1, 0));
    ops.push_back(make_op(noa_pkg::KIND_SLICE, ONES, 0, 0, 64, 64, 63, 1, 1, 0));
    ops.push_back(make_op(noa_pkg::KIND_VEC, 64'hC3FF_FFFF_FFFF_FFFF, 7, 0, 64, 64, 0,
                          8, 8, 0));
    ops.push_back(make_op(noa_pkg::KIND_VEC, 64'h1234, 2, ONES, 64, 64, 0, 3, 40, 1));
    ops.push_back(make_op(noa_pkg::KIND_VEC, ONES, 5, 0, 64, 64, 0, 0, 8, 0));
    ops.push_back(make_op(KIND_UNUSED_TOP, ONES, ONES, ONES, 64, 64, 63, 127, 64, 1));
    foreach (ops[i]) push_op(ops[i]);
  endtask

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= 1'b0;
    in_valid <= 1'b0;
    in_kind <= '0;
    in_operand_a <= '0;
    in_operand_b <= '0;
    in_operand_c <= '0;
    in_result_width <= '0;
    in_source_width <= '0;
    in_bit_offset <= '0;
    in_element_count <= '0;
    in_element_width <= '0;
    in_inject_mode <= 1'b0;
    calm <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int ph = 0; ph < 3; ph++) begin
      write_strict(ph != 1);
      if (ph == 0) run_directed();
      for (int i = 0; i < RAND_PER_PHASE; i++) begin
        calm <= (ph == 1 && i >= 60 && i < 140);
        push_op(rand_op());
      end
      calm <= 1'b0;
      settle();
    end
    ledger.drain_check();
    if (ledger.errors == 0) begin
      $display("netlist_operator_alu: match");
    end else begin
      $display("netlist_operator_alu: mismatch");
    end
    $finish;
  end

endmodule
